// ----- hdl/aes128_pkg.sv -----
`timescale 1ns / 1ps
package aes128_pkg;

  localparam int unsigned Rounds = 10;

  typedef logic [127:0] block_t;

  localparam logic [7:0] SboxTab [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RconTab [Rounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte 0 is the top byte of the word
  function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
    get_byte = b[127 - 8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(4*c + r) -: 8] = SboxTab[get_byte(s, 4*((c + r) % 4) + r)];
      end
    end
    sub_shift = t;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32*c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                             a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
    end
    mix_columns = t;
  endfunction

  function automatic block_t next_key(input block_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, tw;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    tw = {SboxTab[w3[23:16]] ^ rc, SboxTab[w3[15:8]], SboxTab[w3[7:0]], SboxTab[w3[31:24]]};
    w0 = w0 ^ tw;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

endpackage

// ----- hdl/aes128_block_encrypt_top.sv -----
`timescale 1ns / 1ps
// done_o is the valid bit of the last round stage and marks the cycle in which the cipher word is on the outputs
// throughput: one word per cycle, busy is always low and the receiver cannot stall
// every round has its own register stage, with the key schedule running alongside
// reset clears the valid bits and both key registers to zero
module aes128_block_encrypt_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] plain_high_i,
  input  logic [63:0] plain_low_i,
  output logic        done_o,
  output logic [63:0] cipher_high_o,
  output logic [63:0] cipher_low_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import aes128_pkg::*;

  localparam logic [3:0] AddrKeyHigh = 4'd0;
  localparam logic [3:0] AddrKeyLow  = 4'd8;

  logic [63:0] key_high_q, key_low_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (wr_en) begin
      if (paddr == AddrKeyHigh) key_high_q <= pwdata;
      if (paddr == AddrKeyLow)  key_low_q  <= pwdata;
    end
  end

  always_comb begin
    case (paddr)
      AddrKeyHigh: prdata = key_high_q;
      AddrKeyLow:  prdata = key_low_q;
      default:     prdata = '0;
    endcase
  end

  // stage r holds the state after round r and round key r
  logic         vld_q [Rounds+1];
  block_t       st_q  [Rounds+1];
  block_t       rk_q  [Rounds+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r <= Rounds; r++) vld_q[r] <= 1'b0;
    end else begin
      vld_q[0] <= start;
      for (int r = 1; r <= Rounds; r++) vld_q[r] <= vld_q[r-1];
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= {plain_high_i, plain_low_i} ^ {key_high_q, key_low_q};
    rk_q[0] <= {key_high_q, key_low_q};
    for (int r = 1; r <= Rounds; r++) begin
      rk_q[r] <= next_key(rk_q[r-1], RconTab[r-1]);
      if (r == Rounds) begin
        st_q[r] <= sub_shift(st_q[r-1]) ^ next_key(rk_q[r-1], RconTab[r-1]);
      end else begin
        st_q[r] <= mix_columns(sub_shift(st_q[r-1])) ^ next_key(rk_q[r-1], RconTab[r-1]);
      end
    end
  end

  assign done_o        = vld_q[Rounds];
  assign cipher_high_o = st_q[Rounds][127:64];
  assign cipher_low_o  = st_q[Rounds][63:0];

endmodule

// ----- hdl/aes128_checker.sv -----
`timescale 1ns / 1ps
module aes128_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic pready
);
  a_busy_low: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy high");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##11 done_o) else $error("word lost");
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!start ##11 1'b1) |-> !done_o) else $error("spurious word");
endmodule

bind aes128_block_encrypt_top aes128_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .done_o(done_o), .pready(pready)
);

// ----- dv/aes128_block_encrypt_top_tb.sv -----
`timescale 1ns / 1ps
module aes128_block_encrypt_top_tb;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [63:0] plain_high_i;
  logic [63:0] plain_low_i;
  logic        done_o;
  logic [63:0] cipher_high_o;
  logic [63:0] cipher_low_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  localparam logic [3:0] AddrKeyHigh = 4'd0;
  localparam logic [3:0] AddrKeyLow  = 4'd8;
  localparam int unsigned CycleLimit = 400000;

  aes128_block_encrypt_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .plain_high_i(plain_high_i), .plain_low_i(plain_low_i),
    .done_o(done_o), .cipher_high_o(cipher_high_o), .cipher_low_o(cipher_low_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [127:0] plain_q[$];
  logic [127:0] cipher_exp_q[$];
  logic [7:0]   sbox_lut[256];
  logic [127:0] cipher_key;
  int unsigned  words_sent, words_checked, mismatches, cycles, key_count;
  int unsigned  burst_left, gap_left;
  logic         hold_sender;

  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    gf_dbl = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_dbl(a);
    end
    gf_mul = p;
  endfunction

  function automatic logic [7:0] sbox_entry(input logic [7:0] x);
    logic [7:0] inv, y;
    inv = 8'h01;
    for (int i = 0; i < 254; i++) inv = gf_mul(inv, x);
    if (x == 8'h00) inv = 8'h00;
    y = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
        ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    sbox_entry = y;
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] pt, input logic [127:0] key);
    logic [7:0] rk[176];
    logic [7:0] s[16];
    logic [7:0] t[16];
    logic [7:0] w0, w1, w2, w3, u, a0, a1, a2, a3, all, rc;
    logic [127:0] res;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127 - 8*i -: 8];
      s[i] = pt[127 - 8*i -: 8] ^ rk[i];
    end
    for (int i = 16; i < 176; i += 4) begin
      w0 = rk[i-4]; w1 = rk[i-3]; w2 = rk[i-2]; w3 = rk[i-1];
      if (i % 16 == 0) begin
        u = w0;
        w0 = sbox_lut[w1] ^ rc;
        w1 = sbox_lut[w2];
        w2 = sbox_lut[w3];
        w3 = sbox_lut[u];
        rc = gf_dbl(rc);
      end
      rk[i] = rk[i-16] ^ w0;
      rk[i+1] = rk[i-15] ^ w1;
      rk[i+2] = rk[i-14] ^ w2;
      rk[i+3] = rk[i-13] ^ w3;
    end
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[4*c + r] = sbox_lut[s[4*((c + r) % 4) + r]];
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ all ^ gf_dbl(a0 ^ a1);
          t[4*c+1] = a1 ^ all ^ gf_dbl(a1 ^ a2);
          t[4*c+2] = a2 ^ all ^ gf_dbl(a2 ^ a3);
          t[4*c+3] = a3 ^ all ^ gf_dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*rnd + i];
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = s[i];
    aes_encrypt = res;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // sender: bursts and gaps, pauses on hold
  always @(negedge clk_i) begin
    if (!rst_ni || hold_sender || plain_q.size() == 0) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else begin
      start <= 1'b1;
      plain_high_i <= plain_q[0][127:64];
      plain_low_i <= plain_q[0][63:0];
      if (burst_left > 1) begin
        burst_left <= burst_left - 1;
      end else begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (start && !busy && rst_ni) begin
      cipher_exp_q.push_back(aes_encrypt({plain_high_i, plain_low_i}, cipher_key));
      void'(plain_q.pop_front());
      words_sent <= words_sent + 1;
    end
  end

  always @(posedge clk_i) begin
    logic [127:0] want;
    if (rst_ni && done_o) begin
      if (cipher_exp_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected word %h_%h", cipher_high_o, cipher_low_o);
      end else begin
        want = cipher_exp_q.pop_front();
        words_checked <= words_checked + 1;
        if (want != {cipher_high_o, cipher_low_o}) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp %h_%h got %h_%h", want[127:64], want[63:0],
                     cipher_high_o, cipher_low_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrKeyHigh) cipher_key[127:64] = data;
    else cipher_key[63:0] = data;
  endtask

  task automatic load_key(input logic [127:0] key);
    apb_write(AddrKeyHigh, key[127:64]);
    apb_write(AddrKeyLow, key[63:0]);
    key_count++;
  endtask

  task automatic drain();
    wait (plain_q.size() == 0 && cipher_exp_q.size() == 0);
    repeat (15) @(posedge clk_i);
  endtask

  function automatic logic [127:0] rand_block();
    rand_block = {$urandom, $urandom, $urandom, $urandom};
  endfunction

  initial begin
    logic [127:0] key;
    start = 1'b0; plain_high_i = '0; plain_low_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    hold_sender = 1'b0; burst_left = 4; gap_left = 0;
    words_sent = 0; words_checked = 0; mismatches = 0; cycles = 0; key_count = 0;
    cipher_key = '0;
    for (int i = 0; i < 256; i++) sbox_lut[i] = sbox_entry(i[7:0]);
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset key, directed plaintexts
    plain_q.push_back('0);
    plain_q.push_back('1);
    plain_q.push_back(128'h00112233445566778899aabbccddeeff);
    plain_q.push_back({8{16'h55aa}});
    plain_q.push_back({8{16'haa55}});
    plain_q.push_back(128'h1 << 127);
    plain_q.push_back(128'h1);
    drain();

    load_key(128'h000102030405060708090a0b0c0d0e0f);
    plain_q.push_back(128'h00112233445566778899aabbccddeeff);
    plain_q.push_back('0);
    drain();

    load_key(128'h2b7e151628aed2a6abf7158809cf4f3c);
    plain_q.push_back(128'h3243f6a8885a308d313198a2e0370734);
    plain_q.push_back('1);
    drain();

    load_key('1);
    plain_q.push_back('0);
    plain_q.push_back('1);
    for (int i = 0; i < 6; i++) plain_q.push_back(rand_block());
    drain();

    // random keys, the all-zero key at the end
    for (int ph = 0; ph < 8; ph++) begin
      key = (ph == 7) ? '0 : rand_block();
      load_key(key);
      if (ph == 3) hold_sender = 1'b1;
      for (int i = 0; i < 190; i++) plain_q.push_back(rand_block());
      if (ph == 3) begin
        repeat (20) @(posedge clk_i);
        @(negedge clk_i);
        hold_sender = 1'b0;
      end
      if (ph == 5) begin
        wait (plain_q.size() < 90);
        @(negedge clk_i);
        hold_sender = 1'b1;
        wait (cipher_exp_q.size() == 0);
        @(negedge clk_i);
        hold_sender = 1'b0;
      end
      drain();
    end

    if (cipher_exp_q.size() != 0) mismatches++;
    $display("sent %0d blocks under %0d keys, checked %0d ciphertexts, %0d mismatches",
             words_sent, key_count, words_checked, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
